// ----- rtl/phl_pkg.sv -----
// Shared constants and types for the perfect hash lookup block.
package phl_pkg;

   localparam int DEF_BUCKETS  = 64;
   localparam int DEF_SLOTS    = 1024;
   localparam int DEF_KEY_BITS = 16;

   localparam int TYPE_W    = 2;
   localparam int INDEX_W   = 10;
   localparam int KEY_W     = 16;
   localparam int COEF_W    = 7;
   localparam int SPAN_W    = 11;
   localparam int BASE_W    = 10;
   localparam int BHIT_W    = 6;
   localparam int SHIT_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 7;

   // Remainder bits resolved per pipeline stage.
   localparam int MOD_STEPS = 4;

   localparam logic [CSR_W-1:0] PRIME_RESET        = 7'd107;
   localparam logic [CSR_W-1:0] FIRST_MULT_RESET   = 7'd1;
   localparam logic [CSR_W-1:0] FIRST_ADD_RESET    = 7'd0;
   localparam logic [CSR_W-1:0] BUCKET_COUNT_RESET = 7'd64;

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD_BUCKET = 2'd0,
      REQ_LOAD_SLOT   = 2'd1,
      REQ_LOOKUP      = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRIME        = 2'd0,
      CSR_FIRST_MULT   = 2'd1,
      CSR_FIRST_ADD    = 2'd2,
      CSR_BUCKET_COUNT = 2'd3
   } csr_index_type;

endpackage

// ----- rtl/phl_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module phl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/phl_mod.sv -----
// Pipelined restoring remainder unit that carries a payload alongside.
module phl_mod #(
   parameter int DW = 24,
   parameter int MW = 7,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_dividend,
   input  logic [MW-1:0] in_divisor,
   input  logic [PW-1:0] in_payload,
   output logic          out_valid,
   output logic [DW-1:0] out_result,
   output logic [PW-1:0] out_payload
);

   localparam int STEPS  = phl_pkg::MOD_STEPS;
   localparam int STAGES = (DW + STEPS - 1) / STEPS;
   localparam int PADW   = STAGES * STEPS;

   logic            valid_ff [STAGES];
   logic            valid_in [STAGES];
   logic [PADW-1:0] num_ff   [STAGES];
   logic [PADW-1:0] num_in   [STAGES];
   logic [MW-1:0]   rem_ff   [STAGES];
   logic [MW-1:0]   rem_in   [STAGES];
   logic [MW-1:0]   div_ff   [STAGES];
   logic [MW-1:0]   div_in   [STAGES];
   logic [DW-1:0]   orig_ff  [STAGES];
   logic [DW-1:0]   orig_in  [STAGES];
   logic [PW-1:0]   pay_ff   [STAGES];
   logic [PW-1:0]   pay_in   [STAGES];

   // Each stage shifts in STEPS dividend bits, most significant first.
   always_comb begin
      logic [PADW-1:0] num;
      logic [MW-1:0]   rem;
      logic [MW:0]     t;
      logic [MW-1:0]   dv;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            num         = PADW'(in_dividend);
            rem         = '0;
            dv          = in_divisor;
            valid_in[s] = in_valid;
            orig_in[s]  = in_dividend;
            pay_in[s]   = in_payload;
         end else begin
            num         = num_ff[s-1];
            rem         = rem_ff[s-1];
            dv          = div_ff[s-1];
            valid_in[s] = valid_ff[s-1];
            orig_in[s]  = orig_ff[s-1];
            pay_in[s]   = pay_ff[s-1];
         end
         for (int k = 0; k < STEPS; k++) begin
            t   = {rem, num[PADW-1]};
            num = num << 1;
            if (t >= {1'b0, dv}) begin
               t = t - {1'b0, dv};
            end
            rem = t[MW-1:0];
         end
         num_in[s] = num;
         rem_in[s] = rem;
         div_in[s] = dv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STAGES; s++) begin
            num_ff[s]  <= num_in[s];
            rem_ff[s]  <= rem_in[s];
            div_ff[s]  <= div_in[s];
            orig_ff[s] <= orig_in[s];
            pay_ff[s]  <= pay_in[s];
         end
      end
   end

   // A zero divisor passes the dividend through unreduced.
   assign out_valid   = valid_ff[STAGES-1];
   assign out_result  = (div_ff[STAGES-1] == '0) ? orig_ff[STAGES-1]
                                                 : DW'(rem_ff[STAGES-1]);
   assign out_payload = pay_ff[STAGES-1];

endmodule

// ----- rtl/perfect_hash_lookup.sv -----
// Most of the pipeline depth lies in the five remainder pipelines, which resolve
// four bits per stage. Throughput: one request per cycle; the pipeline only halts
// when the two-entry output buffer is full. Reset is synchronous and active high;
// after it the bucket and slot memories are swept clear over max(SLOTS, BUCKETS)
// addresses (1024 by default) while req_stall stays high. Register writes are
// taken at any time.
module perfect_hash_lookup #(
   parameter int BUCKETS  = phl_pkg::DEF_BUCKETS,
   parameter int SLOTS    = phl_pkg::DEF_SLOTS,
   parameter int KEY_BITS = phl_pkg::DEF_KEY_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [phl_pkg::TYPE_W-1:0]     req_type,
   input  logic [phl_pkg::INDEX_W-1:0]    req_target_index,
   input  logic [phl_pkg::KEY_W-1:0]      req_key_value,
   input  logic [phl_pkg::COEF_W-1:0]     req_bucket_mult,
   input  logic [phl_pkg::COEF_W-1:0]     req_bucket_add,
   input  logic [phl_pkg::SPAN_W-1:0]     req_bucket_span,
   input  logic [phl_pkg::BASE_W-1:0]     req_bucket_base,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [phl_pkg::BHIT_W-1:0]     rsp_bucket_hit,
   output logic [phl_pkg::SHIT_W-1:0]     rsp_slot_hit,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [phl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [phl_pkg::CSR_W-1:0]      csr_wdata
);

   // Keys wider than the request field cannot arrive, so the store keeps at most that.
   localparam int KW   = (KEY_BITS < phl_pkg::KEY_W) ? KEY_BITS : phl_pkg::KEY_W;
   localparam int VW   = phl_pkg::COEF_W + KW + 1;
   localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SW   = $clog2(SLOTS);
   localparam int SMW  = $clog2(SLOTS + 1);
   localparam int CD   = (SLOTS > BUCKETS) ? SLOTS : BUCKETS;
   localparam int CW   = $clog2(CD);
   localparam int SUMW = phl_pkg::BASE_W + 2;

   typedef struct packed {
      logic [phl_pkg::TYPE_W-1:0]  kind;
      logic [KW-1:0]               key;
      logic [phl_pkg::INDEX_W-1:0] target;
      logic [phl_pkg::COEF_W-1:0]  mult;
      logic [phl_pkg::COEF_W-1:0]  add;
      logic [phl_pkg::SPAN_W-1:0]  span;
      logic [phl_pkg::BASE_W-1:0]  base;
   } front_type;

   typedef struct packed {
      logic [phl_pkg::TYPE_W-1:0]  kind;
      logic [KW-1:0]               key;
      logic [phl_pkg::INDEX_W-1:0] target;
      logic [phl_pkg::BHIT_W-1:0]  bhit;
   } mid_type;

   typedef struct packed {
      logic [phl_pkg::TYPE_W-1:0]  kind;
      logic [KW-1:0]               key;
      logic [phl_pkg::INDEX_W-1:0] target;
      logic [phl_pkg::BHIT_W-1:0]  bhit;
      logic [phl_pkg::SPAN_W-1:0]  span;
      logic [phl_pkg::BASE_W-1:0]  base;
   } back_type;

   typedef struct packed {
      logic [phl_pkg::COEF_W-1:0] mult;
      logic [phl_pkg::COEF_W-1:0] add;
      logic [phl_pkg::SPAN_W-1:0] span;
      logic [phl_pkg::BASE_W-1:0] base;
   } bucket_entry_type;

   typedef struct packed {
      logic                        found;
      logic [phl_pkg::BHIT_W-1:0]  bucket_hit;
      logic [phl_pkg::SHIT_W-1:0]  slot_hit;
   } result_type;

   // ---------------------------------------------------------------------------
   // Configuration registers. Every stage reads them live, so they must only change
   // while no request is in flight; the block itself does not enforce this.
   // ---------------------------------------------------------------------------
   logic [phl_pkg::CSR_W-1:0]  prime_ff, fmult_ff, fadd_ff, bcount_ff;
   logic [phl_pkg::SPAN_W-1:0] n_eff;
   logic                       n_nz;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff  <= phl_pkg::PRIME_RESET;
         fmult_ff  <= phl_pkg::FIRST_MULT_RESET;
         fadd_ff   <= phl_pkg::FIRST_ADD_RESET;
         bcount_ff <= phl_pkg::BUCKET_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (phl_pkg::csr_index_type'(csr_index))
            phl_pkg::CSR_PRIME:        prime_ff  <= csr_wdata;
            phl_pkg::CSR_FIRST_MULT:   fmult_ff  <= csr_wdata;
            phl_pkg::CSR_FIRST_ADD:    fadd_ff   <= csr_wdata;
            phl_pkg::CSR_BUCKET_COUNT: bcount_ff <= csr_wdata;
         endcase
      end
   end

   // A bucket count above the table size uses the whole table.
   assign n_eff = (32'(bcount_ff) > BUCKETS) ? phl_pkg::SPAN_W'(BUCKETS)
                                              : phl_pkg::SPAN_W'(bcount_ff);
   assign n_nz  = (n_eff != '0);

   // ---------------------------------------------------------------------------
   // Clearing sweep after reset. Both memories are written with zeros, one
   // address a cycle, while requests are held off.
   // ---------------------------------------------------------------------------
   logic          clearing_ff;
   logic [CW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == CW'(CD - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control. All stages advance together unless the output buffer is
   // full; a result still waiting there does not block new transfers.
   // ---------------------------------------------------------------------------
   logic [1:0] cnt_ff, cnt_in;
   logic       en, accept, push, pop;

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = clearing_ff || !en;
   assign accept    = req_valid && !req_stall;

   // Stage 0: input register.
   logic      s0_valid_ff;
   front_type s0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff.kind   <= req_type;
         s0_ff.key    <= KW'(req_key_value);
         s0_ff.target <= req_target_index;
         s0_ff.mult   <= req_bucket_mult;
         s0_ff.add    <= req_bucket_add;
         s0_ff.span   <= req_bucket_span;
         s0_ff.base   <= req_bucket_base;
      end
   end

   // Stage 1: first-level affine term a*key + b.
   logic          s1_valid_ff;
   front_type     s1_ff;
   logic [VW-1:0] s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s0_ff;
         s1_v_ff <= VW'(s0_ff.key) * VW'(fmult_ff) + VW'(fadd_ff);
      end
   end

   // First level: reduce by the prime, then by the bucket count.
   logic                   p1_valid, n_valid;
   logic [VW-1:0]          p1_res, n_res;
   logic [$bits(front_type)-1:0] p1_pay, n_pay;

   phl_mod #(.DW(VW), .MW(phl_pkg::COEF_W), .PW($bits(front_type))) u_mod_p1 (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s1_valid_ff),
      .in_dividend (s1_v_ff),
      .in_divisor  (prime_ff),
      .in_payload  (s1_ff),
      .out_valid   (p1_valid),
      .out_result  (p1_res),
      .out_payload (p1_pay)
   );

   phl_mod #(.DW(VW), .MW(phl_pkg::SPAN_W), .PW($bits(front_type))) u_mod_n (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (p1_valid),
      .in_dividend (p1_res),
      .in_divisor  (n_eff),
      .in_payload  (p1_pay),
      .out_valid   (n_valid),
      .out_result  (n_res),
      .out_payload (n_pay)
   );

   // Bucket stage: a bucket load writes the parameter memory here, a lookup
   // reads its bucket. Both happen in request order at the same stage.
   front_type        bf;
   logic [BW-1:0]    h1;
   logic             bkt_we;
   logic [BW-1:0]    bkt_waddr;
   bucket_entry_type bkt_wdata, bkt_rdata;

   assign bf = front_type'(n_pay);
   assign h1 = n_nz ? BW'(n_res) : '0;

   always_comb begin
      if (clearing_ff) begin
         bkt_we    = (32'(clr_ff) < BUCKETS);
         bkt_waddr = BW'(clr_ff);
         bkt_wdata = '0;
      end else begin
         bkt_we    = en && n_valid && (bf.kind == phl_pkg::REQ_LOAD_BUCKET)
                     && (32'(bf.target) < BUCKETS);
         bkt_waddr = BW'(bf.target);
         bkt_wdata = '{mult: bf.mult, add: bf.add, span: bf.span, base: bf.base};
      end
   end

   phl_ram #(.WIDTH($bits(bucket_entry_type)), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock (clock),
      .we    (bkt_we),
      .waddr (bkt_waddr),
      .wdata (bkt_wdata),
      .re    (en),
      .raddr (h1),
      .rdata (bkt_rdata)
   );

   // Stage 2: request fields line up with the bucket read data.
   logic    s2_valid_ff;
   mid_type s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= n_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff.kind   <= bf.kind;
         s2_ff.key    <= bf.key;
         s2_ff.target <= bf.target;
         s2_ff.bhit   <= (bf.kind == phl_pkg::REQ_LOOKUP && n_nz)
                         ? phl_pkg::BHIT_W'(h1) : '0;
      end
   end

   // Stage 3: second-level affine term with the bucket's own coefficients.
   logic          s3_valid_ff;
   back_type      s3_ff;
   logic [VW-1:0] s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff.kind   <= s2_ff.kind;
         s3_ff.key    <= s2_ff.key;
         s3_ff.target <= s2_ff.target;
         s3_ff.bhit   <= s2_ff.bhit;
         s3_ff.span   <= bkt_rdata.span;
         s3_ff.base   <= bkt_rdata.base;
         s3_v_ff      <= VW'(s2_ff.key) * VW'(bkt_rdata.mult) + VW'(bkt_rdata.add);
      end
   end

   // Second level: reduce by the prime, then by the bucket's slot count. An
   // empty bucket's result is discarded further down.
   logic                        p2_valid, sp_valid, sl_valid;
   logic [VW-1:0]               p2_res, sp_res;
   logic [SUMW-1:0]             sl_res, sum;
   logic [$bits(back_type)-1:0] p2_pay, sp_pay, sl_pay;
   back_type                    p2_b, sp_b;

   assign p2_b = back_type'(p2_pay);
   assign sp_b = back_type'(sp_pay);

   phl_mod #(.DW(VW), .MW(phl_pkg::COEF_W), .PW($bits(back_type))) u_mod_p2 (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s3_valid_ff),
      .in_dividend (s3_v_ff),
      .in_divisor  (prime_ff),
      .in_payload  (s3_ff),
      .out_valid   (p2_valid),
      .out_result  (p2_res),
      .out_payload (p2_pay)
   );

   phl_mod #(.DW(VW), .MW(phl_pkg::SPAN_W), .PW($bits(back_type))) u_mod_span (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (p2_valid),
      .in_dividend (p2_res),
      .in_divisor  (p2_b.span),
      .in_payload  (p2_pay),
      .out_valid   (sp_valid),
      .out_result  (sp_res),
      .out_payload (sp_pay)
   );

   // The probed slot wraps around the end of the slot store.
   assign sum = SUMW'(sp_b.base) + SUMW'(sp_res[phl_pkg::SPAN_W-1:0]);

   phl_mod #(.DW(SUMW), .MW(SMW), .PW($bits(back_type))) u_mod_slot (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (sp_valid),
      .in_dividend (sum),
      .in_divisor  (SMW'(SLOTS)),
      .in_payload  (sp_pay),
      .out_valid   (sl_valid),
      .out_result  (sl_res),
      .out_payload (sl_pay)
   );

   // Slot stage: a slot load writes the key store, a lookup probes it.
   back_type                   sf;
   logic                       look, probe;
   logic [SW-1:0]              slot_raddr, slot_waddr;
   logic [phl_pkg::SHIT_W-1:0] slot_hit;
   logic                       slot_we;
   logic [KW:0]                slot_wdata, slot_rdata;

   assign sf       = back_type'(sl_pay);
   assign look     = (sf.kind == phl_pkg::REQ_LOOKUP) && n_nz;
   assign probe    = look && (sf.span != '0);
   assign slot_hit = (sf.span == '0) ? sf.base : phl_pkg::SHIT_W'(sl_res);
   assign slot_raddr = probe ? SW'(sl_res) : '0;

   always_comb begin
      if (clearing_ff) begin
         slot_we    = (32'(clr_ff) < SLOTS);
         slot_waddr = SW'(clr_ff);
         slot_wdata = '0;
      end else begin
         slot_we    = en && sl_valid && (sf.kind == phl_pkg::REQ_LOAD_SLOT)
                      && (32'(sf.target) < SLOTS);
         slot_waddr = SW'(sf.target);
         slot_wdata = {1'b1, sf.key};
      end
   end

   phl_ram #(.WIDTH(KW + 1), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (en),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // Stage 5: key compare against the slot read data.
   logic                       s5_valid_ff, s5_probe_ff;
   logic [KW-1:0]              s5_key_ff;
   logic [phl_pkg::BHIT_W-1:0] s5_bhit_ff;
   logic [phl_pkg::SHIT_W-1:0] s5_shit_ff;
   result_type                 res;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= sl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_probe_ff <= probe;
         s5_key_ff   <= sf.key;
         s5_bhit_ff  <= sf.bhit;
         s5_shit_ff  <= look ? slot_hit : '0;
      end
   end

   assign res.found      = s5_probe_ff && slot_rdata[KW] && (slot_rdata[KW-1:0] == s5_key_ff);
   assign res.bucket_hit = s5_bhit_ff;
   assign res.slot_hit   = s5_shit_ff;

   // ---------------------------------------------------------------------------
   // Two-entry output buffer.
   // ---------------------------------------------------------------------------
   result_type fifo_ff [2];
   logic       rd_ptr_ff, wr_ptr_ff;

   assign push   = s5_valid_ff && en;
   assign pop    = (cnt_ff != 2'd0) && !rsp_stall;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res;
      end
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_found      = fifo_ff[rd_ptr_ff].found;
   assign rsp_bucket_hit = fifo_ff[rd_ptr_ff].bucket_hit;
   assign rsp_slot_hit   = fifo_ff[rd_ptr_ff].slot_hit;

endmodule

// ----- rtl/phl_checker.sv -----
// Port-level assertions for the perfect hash lookup block, with its bind.
module phl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_found,
   input logic [phl_pkg::BHIT_W-1:0] rsp_bucket_hit,
   input logic [phl_pkg::SHIT_W-1:0] rsp_slot_hit
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_bucket_hit) && $stable(rsp_slot_hit))
      else $error("stalled result changed");

   // Reset starts the clearing sweep with nothing in flight.
   assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("reset did not hold off requests");

   // With the output buffer empty, it cannot be full in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_stall |=> !req_stall)
      else $error("input stalled with an empty output buffer");

endmodule

bind perfect_hash_lookup phl_checker u_checker (.*);
